>>> hw/rtl/spcr_pkg.sv
// ----------------------------------------------------------------------------
// spcr_pkg: shared types and constants for the sphere pair collision block
// Input and result beat structs, register map and widths.
// ----------------------------------------------------------------------------
package spcr_pkg;

	localparam int unsigned DataW = 32;
	localparam logic [DataW-1:0] SpringGainReset = 32'd6553600;
	localparam int unsigned AddrW = 2;
	localparam logic [AddrW-1:0] RegSpringGain = 2'd0;

	typedef struct packed {
		logic signed [31:0] delta_x;
		logic signed [31:0] delta_y;
		logic signed [31:0] delta_z;
		logic signed [31:0] rel_vel_x;
		logic signed [31:0] rel_vel_y;
		logic signed [31:0] rel_vel_z;
		logic [31:0] radius_a;
		logic [31:0] radius_b;
		logic [31:0] mass_a;
		logic [31:0] mass_b;
	} pair_in_t;

	typedef struct packed {
		logic hit;
		logic body;
		logic is_last;
		logic signed [31:0] force_x;
		logic signed [31:0] force_y;
		logic signed [31:0] force_z;
		logic signed [31:0] dvel_x;
		logic signed [31:0] dvel_y;
		logic signed [31:0] dvel_z;
	} pair_out_t;

	// saturate a signed product scaled down by 2^16 (magnitude form)
	function automatic logic signed [31:0] scale_sat(input logic [63:0] mag,
			input logic neg, input logic signed [17:0] n);
		logic [16:0] an;
		logic [80:0] p;
		logic [64:0] m;
		logic s;
		an = n[17] ? 17'(-n) : n[16:0];
		p = mag * an;
		m = p[80:16];
		s = neg ^ n[17];
		if (m > 65'h80000000) m = 65'h80000000;
		if (s) scale_sat = (m == 65'h80000000) ? 32'sh80000000 : -$signed(m[31:0]);
		else scale_sat = (m == 65'h80000000) ? 32'sh7fffffff : $signed(m[31:0]);
	endfunction

endpackage

>>> hw/rtl/spcr_divpipe.sv
// ----------------------------------------------------------------------------
// spcr_divpipe: pipelined unsigned restoring divider with payload
// One quotient bit per stage; a new beat may enter every cycle.
// ----------------------------------------------------------------------------
module spcr_divpipe #(
	parameter int unsigned NumW = 96,
	parameter int unsigned DenW = 64,
	parameter int unsigned TagW = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic [NumW-1:0] num,
	input  logic [DenW-1:0] den,
	input  logic [TagW-1:0] tag_in,
	output logic out_valid,
	output logic [NumW-1:0] quo,
	output logic [TagW-1:0] tag_out
);
	logic [NumW-1:0] q_s [NumW+1];
	logic [DenW:0] r_s [NumW+1];
	logic [DenW-1:0] d_s [NumW+1];
	logic [TagW-1:0] t_s [NumW+1];
	logic v_s [NumW+1];

	assign q_s[0] = num;
	assign r_s[0] = '0;
	assign d_s[0] = den;
	assign t_s[0] = tag_in;
	assign v_s[0] = in_valid;

	// one stage per quotient bit, shifting the numerator out msb first
	for (genvar g = 0; g < NumW; g++) begin : g_st
		logic [DenW+1:0] sh;
		logic ge;
		assign sh = {r_s[g], q_s[g][NumW-1]};
		assign ge = sh >= {2'b0, d_s[g]};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[g+1] <= 1'b0;
			else v_s[g+1] <= v_s[g];
		end
		always_ff @(posedge clk) begin
			r_s[g+1] <= ge ? (DenW+1)'(sh - {2'b0, d_s[g]}) : sh[DenW:0];
			q_s[g+1] <= {q_s[g][NumW-2:0], ge};
			d_s[g+1] <= d_s[g];
			t_s[g+1] <= t_s[g];
		end
	end

	assign out_valid = v_s[NumW];
	assign quo = q_s[NumW];
	assign tag_out = t_s[NumW];
endmodule

>>> hw/rtl/sphere_pair_collision_response.sv
// ----------------------------------------------------------------------------
// sphere_pair_collision_response: spring force and elastic velocity change
// for one overlapping sphere pair per beat, Q16.16 saturated.
// ----------------------------------------------------------------------------
// channel  | handshake            | payload
// in       | start & !busy        | in_data  (spcr_pkg::pair_in_t)
// out      | done per beat        | out_data (spcr_pkg::pair_out_t)
// cfg      | APB psel&penable     | spring_gain at 0x0
// A pair enters only while busy is low (busy high in the cycle after an accepted start);
// the output runs one result per cycle, so a hit pair's two beats never collide.
// The A beat passes squares, square root, overlap, normal divider, products,
// the spring and impulse dividers (side by side) and the output register; on a
// hit the B beat follows in the next cycle.
// Reset clears all valid bits and restores spring_gain; the receiver
// cannot stall, so the pipeline never stops.
// ----------------------------------------------------------------------------
module sphere_pair_collision_response #(
	parameter logic [31:0] GainReset = spcr_pkg::SpringGainReset
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  spcr_pkg::pair_in_t in_data,
	output logic done,
	output spcr_pkg::pair_out_t out_data,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [spcr_pkg::AddrW-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	localparam int unsigned Lat = 32;

	// config register
	logic [31:0] gain_q;
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) gain_q <= GainReset;
		else if (psel && penable && pwrite && paddr == spcr_pkg::RegSpringGain)
			gain_q <= pwdata;
	end
	assign prdata = (paddr == spcr_pkg::RegSpringGain) ? gain_q : '0;

	// entry: a start is taken only while busy is low
	logic busy_q;
	logic acc;
	assign acc = start && !busy_q;
	assign busy = busy_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) busy_q <= 1'b0;
		else busy_q <= acc;
	end

	// stage 1: squares
	logic v_s1;
	spcr_pkg::pair_in_t p_s1;
	logic [63:0] sx_s1, sy_s1, sz_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else v_s1 <= acc;
	end
	always_ff @(posedge clk) begin
		p_s1 <= in_data;
		sx_s1 <= 64'($signed(in_data.delta_x) * $signed(in_data.delta_x));
		sy_s1 <= 64'($signed(in_data.delta_y) * $signed(in_data.delta_y));
		sz_s1 <= 64'($signed(in_data.delta_z) * $signed(in_data.delta_z));
	end

	// stage 2: sum of squares (fits 64 bits unsigned)
	logic v_s2;
	spcr_pkg::pair_in_t p_s2;
	logic [63:0] sum_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		p_s2 <= p_s1;
		sum_s2 <= sx_s1 + sy_s1 + sz_s1;
	end

	// square root: one result bit per stage
	logic [63:0] sr_s [Lat+1];
	logic [33:0] sq_rem [Lat+1];
	logic [31:0] sq_root [Lat+1];
	spcr_pkg::pair_in_t sp [Lat+1];
	logic sv [Lat+1];
	assign sr_s[0] = sum_s2;
	assign sq_rem[0] = '0;
	assign sq_root[0] = '0;
	assign sp[0] = p_s2;
	assign sv[0] = v_s2;
	for (genvar g = 0; g < Lat; g++) begin : g_sq
		logic [35:0] tr, tt;
		assign tr = {sq_rem[g], sr_s[g][63:62]};
		assign tt = {2'b0, sq_root[g], 2'b01};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sv[g+1] <= 1'b0;
			else sv[g+1] <= sv[g];
		end
		always_ff @(posedge clk) begin
			sr_s[g+1] <= {sr_s[g][61:0], 2'b00};
			sp[g+1] <= sp[g];
			if (tr >= tt) begin
				sq_rem[g+1] <= 34'(tr - tt);
				sq_root[g+1] <= {sq_root[g][30:0], 1'b1};
			end else begin
				sq_rem[g+1] <= tr[33:0];
				sq_root[g+1] <= {sq_root[g][30:0], 1'b0};
			end
		end
	end

	// stage 3: overlap and normal division operands
	logic [31:0] dist_s3;
	logic signed [34:0] ovl_s3;
	logic v_s3;
	spcr_pkg::pair_in_t p_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else v_s3 <= sv[Lat];
	end
	always_ff @(posedge clk) begin
		p_s3 <= sp[Lat];
		dist_s3 <= sq_root[Lat];
		ovl_s3 <= $signed({3'b0, sp[Lat].radius_a}) + $signed({3'b0, sp[Lat].radius_b})
			- $signed({3'b0, sq_root[Lat]});
	end
	logic hit_s3;
	assign hit_s3 = !ovl_s3[34];

	// normal: |d|*2^16 / dist per axis (dist 0 gives zero normal below)
	localparam int unsigned NTagW = $bits(spcr_pkg::pair_in_t) + 35 + 3 + 1 + 1;
	logic [47:0] nq_x, nq_y, nq_z;
	logic [NTagW-1:0] ntag_in, ntag_out;
	logic nv;
	logic [31:0] den_n;
	assign den_n = (dist_s3 == 0) ? 32'd1 : dist_s3;
	assign ntag_in = {p_s3, ovl_s3, p_s3.delta_x[31], p_s3.delta_y[31], p_s3.delta_z[31],
		hit_s3, dist_s3 == 0};
	logic [47:0] ax, ay, az;
	assign ax = {p_s3.delta_x[31] ? 32'(-p_s3.delta_x) : p_s3.delta_x, 16'h0};
	assign ay = {p_s3.delta_y[31] ? 32'(-p_s3.delta_y) : p_s3.delta_y, 16'h0};
	assign az = {p_s3.delta_z[31] ? 32'(-p_s3.delta_z) : p_s3.delta_z, 16'h0};
	spcr_divpipe #(.NumW(48), .DenW(32), .TagW(NTagW)) u_nx (
		.clk, .arst_n, .in_valid(v_s3), .num(ax), .den(den_n), .tag_in(ntag_in),
		.out_valid(nv), .quo(nq_x), .tag_out(ntag_out));
	spcr_divpipe #(.NumW(48), .DenW(32), .TagW(1)) u_ny (
		.clk, .arst_n, .in_valid(v_s3), .num(ay), .den(den_n), .tag_in(1'b0),
		.out_valid(), .quo(nq_y), .tag_out());
	spcr_divpipe #(.NumW(48), .DenW(32), .TagW(1)) u_nz (
		.clk, .arst_n, .in_valid(v_s3), .num(az), .den(den_n), .tag_in(1'b0),
		.out_valid(), .quo(nq_z), .tag_out());

	// stage 4: signed normal and overlap
	spcr_pkg::pair_in_t p_s4;
	logic signed [17:0] nx_s4, ny_s4, nz_s4;
	logic [32:0] ovl_s4;
	logic hit_s4, v_s4;
	logic sgx, sgy, sgz, dz;
	spcr_pkg::pair_in_t pn;
	logic [34:0] ovn;
	assign {pn, ovn, sgx, sgy, sgz, hit_s4, dz} = ntag_out;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else v_s4 <= nv;
	end
	always_ff @(posedge clk) begin
		p_s4 <= pn;
		ovl_s4 <= ovn[32:0];
		nx_s4 <= dz ? 18'sd0 : (sgx ? -$signed({1'b0, nq_x[16:0]}) : $signed({1'b0, nq_x[16:0]}));
		ny_s4 <= dz ? 18'sd0 : (sgy ? -$signed({1'b0, nq_y[16:0]}) : $signed({1'b0, nq_y[16:0]}));
		nz_s4 <= dz ? 18'sd0 : (sgz ? -$signed({1'b0, nq_z[16:0]}) : $signed({1'b0, nq_z[16:0]}));
	end
	logic hit_q4;
	always_ff @(posedge clk) hit_q4 <= hit_s4;

	// stage 5: products n*v and gain*overlap (overlap up to 33 bits)
	logic signed [49:0] px_s5, py_s5, pz_s5;
	logic [64:0] go_s5;
	logic signed [17:0] nx_s5, ny_s5, nz_s5;
	spcr_pkg::pair_in_t p_s5;
	logic hit_s5, v_s5;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else v_s5 <= v_s4;
	end
	always_ff @(posedge clk) begin
		px_s5 <= nx_s4 * p_s4.rel_vel_x;
		py_s5 <= ny_s4 * p_s4.rel_vel_y;
		pz_s5 <= nz_s4 * p_s4.rel_vel_z;
		go_s5 <= 65'(gain_q * ovl_s4);
		nx_s5 <= nx_s4; ny_s5 <= ny_s4; nz_s5 <= nz_s4;
		p_s5 <= p_s4;
		hit_s5 <= hit_q4;
	end

	// stage 6: dot = trunc(sum/2^16), magnitude doubled; mass sum
	logic [64:0] dmag_s6;
	logic dneg_s6;
	logic [64:0] go_s6;
	logic [32:0] msum_s6;
	logic signed [17:0] nx_s6, ny_s6, nz_s6;
	spcr_pkg::pair_in_t p_s6;
	logic hit_s6, v_s6;
	logic signed [51:0] dsum;
	logic [51:0] dabs;
	assign dsum = px_s5 + py_s5 + pz_s5;
	assign dabs = dsum[51] ? 52'(-dsum) : dsum;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else v_s6 <= v_s5;
	end
	always_ff @(posedge clk) begin
		dmag_s6 <= {28'b0, dabs[51:16], 1'b0};
		dneg_s6 <= dsum[51] && (dabs[51:16] != 0);
		go_s6 <= go_s5;
		msum_s6 <= p_s5.mass_a + p_s5.mass_b;
		nx_s6 <= nx_s5; ny_s6 <= ny_s5; nz_s6 <= nz_s5;
		p_s6 <= p_s5;
		hit_s6 <= hit_s5;
	end

	// stage 7: numerators for the four divisions (products <= 97 bits)
	logic [96:0] numa_s7, numb_s7, nska_s7, nskb_s7;
	logic [32:0] msum_s7;
	logic [31:0] ra_s7, rb_s7;
	logic dneg_s7, hit_s7, v_s7;
	logic signed [17:0] nx_s7, ny_s7, nz_s7;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s7 <= 1'b0;
		else v_s7 <= v_s6;
	end
	always_ff @(posedge clk) begin
		nska_s7 <= 97'(dmag_s6[63:0] * p_s6.mass_b);
		nskb_s7 <= 97'(dmag_s6[63:0] * p_s6.mass_a);
		numa_s7 <= {32'b0, go_s6};
		numb_s7 <= {32'b0, go_s6};
		msum_s7 <= msum_s6;
		ra_s7 <= (p_s6.radius_a == 0) ? 32'd1 : p_s6.radius_a;
		rb_s7 <= (p_s6.radius_b == 0) ? 32'd1 : p_s6.radius_b;
		dneg_s7 <= dneg_s6;
		hit_s7 <= hit_s6;
		nx_s7 <= nx_s6; ny_s7 <= ny_s6; nz_s7 <= nz_s6;
	end

	// dividers for spring scale and impulse
	localparam int unsigned KTagW = 3 * 18 + 2;
	logic [96:0] qsa, qsb, qka, qkb;
	logic [KTagW-1:0] ktag;
	logic kv;
	logic [32:0] den_m;
	assign den_m = (msum_s7 == 0) ? 33'd1 : msum_s7;
	spcr_divpipe #(.NumW(97), .DenW(33), .TagW(KTagW)) u_sa (
		.clk, .arst_n, .in_valid(v_s7), .num(numa_s7), .den({1'b0, ra_s7}),
		.tag_in({nx_s7, ny_s7, nz_s7, dneg_s7, hit_s7}),
		.out_valid(kv), .quo(qsa), .tag_out(ktag));
	spcr_divpipe #(.NumW(97), .DenW(33), .TagW(1)) u_sb (
		.clk, .arst_n, .in_valid(v_s7), .num(numb_s7), .den({1'b0, rb_s7}), .tag_in(1'b0),
		.out_valid(), .quo(qsb), .tag_out());
	spcr_divpipe #(.NumW(97), .DenW(33), .TagW(1)) u_ka (
		.clk, .arst_n, .in_valid(v_s7), .num(nska_s7), .den(den_m), .tag_in(1'b0),
		.out_valid(), .quo(qka), .tag_out());
	spcr_divpipe #(.NumW(97), .DenW(33), .TagW(1)) u_kb (
		.clk, .arst_n, .in_valid(v_s7), .num(nskb_s7), .den(den_m), .tag_in(1'b0),
		.out_valid(), .quo(qkb), .tag_out());

	// stage 8: cap, scale by normal, saturate into two result beats
	logic signed [17:0] fx, fy, fz;
	logic fdn, fhit;
	assign {fx, fy, fz, fdn, fhit} = ktag;
	logic [63:0] csa, csb, cka, ckb;
	assign csa = (qsa > 97'h800000000000) ? 64'h800000000000 : qsa[63:0];
	assign csb = (qsb > 97'h800000000000) ? 64'h800000000000 : qsb[63:0];
	assign cka = (qka[96:64] != 0) ? '1 : qka[63:0];
	assign ckb = (qkb[96:64] != 0) ? '1 : qkb[63:0];

	spcr_pkg::pair_out_t ra_s8, rb_s8;
	logic v_s8;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s8 <= 1'b0;
		else v_s8 <= kv;
	end
	always_ff @(posedge clk) begin
		if (fhit) begin
			ra_s8 <= '{hit: 1'b1, body: 1'b0, is_last: 1'b0,
				force_x: spcr_pkg::scale_sat(csa, 1'b0, fx),
				force_y: spcr_pkg::scale_sat(csa, 1'b0, fy),
				force_z: spcr_pkg::scale_sat(csa, 1'b0, fz),
				dvel_x: spcr_pkg::scale_sat(cka, !fdn, fx),
				dvel_y: spcr_pkg::scale_sat(cka, !fdn, fy),
				dvel_z: spcr_pkg::scale_sat(cka, !fdn, fz)};
		end else begin
			ra_s8 <= '{hit: 1'b0, body: 1'b0, is_last: 1'b1, default: '0};
		end
		rb_s8 <= '{hit: 1'b1, body: 1'b1, is_last: 1'b1,
			force_x: spcr_pkg::scale_sat(csb, 1'b1, fx),
			force_y: spcr_pkg::scale_sat(csb, 1'b1, fy),
			force_z: spcr_pkg::scale_sat(csb, 1'b1, fz),
			dvel_x: spcr_pkg::scale_sat(ckb, fdn, fx),
			dvel_y: spcr_pkg::scale_sat(ckb, fdn, fy),
			dvel_z: spcr_pkg::scale_sat(ckb, fdn, fz)};
	end
	logic hit8;
	always_ff @(posedge clk) hit8 <= fhit;

	// output: A beat, then B beat in the next cycle on a hit
	logic second_q;
	spcr_pkg::pair_out_t hold_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) second_q <= 1'b0;
		else second_q <= v_s8 && hit8;
	end
	always_ff @(posedge clk) hold_q <= rb_s8;
	assign done = v_s8 || second_q;
	assign out_data = second_q ? hold_q : ra_s8;

	// a start is refused while busy is high, which keeps entries apart, so a B beat never meets a new A beat
	a_no_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(second_q && v_s8)) else $error("result beats collide");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> busy) else $error("busy not raised after start");
	a_b_last: assert property (@(posedge clk) disable iff (!arst_n)
		second_q |-> out_data.is_last && out_data.body) else $error("B beat malformed");
endmodule
